// ----- hdl/alt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alt_pkg
// Shared types and constants for the assembly line tokeniser.
// ----------------------------------------------------------------------------
package alt_pkg;

  // records one source byte can cause, and the width of a count of them
  localparam int REC_SLOTS = 3;
  localparam int CNT_W     = 2;

  // fixed-width part of a record: has_char, text_char, ends_token, token_kind
  localparam int REC_FIXED_W = 14;

  typedef enum logic [2:0] {
    M_IDLE    = 3'd0,
    M_COMMENT = 3'd1,
    M_STRING  = 3'd2,
    M_ESCAPE  = 3'd3,
    M_IDENT   = 3'd4,
    M_NUMBER  = 3'd5,
    M_SIGN    = 3'd6
  } mode_t;

  typedef enum logic [3:0] {
    K_EOF     = 4'd0,
    K_NEWLINE = 4'd1,
    K_PERCENT = 4'd2,
    K_STAR    = 4'd3,
    K_STRING  = 4'd4,
    K_IDENT   = 4'd5,
    K_LABEL   = 4'd6,
    K_NUMBER  = 4'd7,
    K_UNKNOWN = 4'd8
  } kind_t;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  // scanner control state, position counters travel separately
  typedef struct packed {
    mode_t      mode;
    logic       cr_pending;
    logic       line_started;
    logic [7:0] sign_char;
  } scan_ctl_t;

endpackage

// ----- hdl/alt_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alt_step
// Next-state and record logic for one source byte or end of source.
// ----------------------------------------------------------------------------
module alt_step import alt_pkg::*; #(
  parameter int POS_WIDTH = 16,
  parameter int TAB_STOP  = 8,
  parameter int PH_W      = 3,
  parameter int REC_W     = 46
) (
  input  logic                 op,
  input  logic [7:0]           c,
  input  scan_ctl_t            ctl,
  input  logic [POS_WIDTH-1:0] cur_line,
  input  logic [POS_WIDTH-1:0] cur_col,
  input  logic [PH_W-1:0]      cur_ph,
  input  logic [POS_WIDTH-1:0] tok_row,
  input  logic [POS_WIDTH-1:0] tok_col,
  output scan_ctl_t            ctl_nxt,
  output logic [POS_WIDTH-1:0] cur_line_nxt,
  output logic [POS_WIDTH-1:0] cur_col_nxt,
  output logic [PH_W-1:0]      cur_ph_nxt,
  output logic [POS_WIDTH-1:0] tok_row_nxt,
  output logic [POS_WIDTH-1:0] tok_col_nxt,
  output logic [CNT_W-1:0]     rec_cnt,
  output logic [REC_W-1:0]     recs [REC_SLOTS]
);

  localparam longint unsigned POS_MAX_L = (64'd1 << POS_WIDTH) - 64'd1;
  localparam logic [POS_WIDTH-1:0] POS_MAX = POS_WIDTH'(POS_MAX_L);
  localparam logic [PH_W-1:0] MAX_PH = PH_W'((POS_MAX_L - 64'd1) % TAB_STOP);
  localparam int STEP_W = $clog2(TAB_STOP + 1);

  function automatic logic [REC_W-1:0] mk_rec(input logic h, input logic [7:0] ch,
                                              input logic e, input kind_t k,
                                              input logic [POS_WIDTH-1:0] ln,
                                              input logic [POS_WIDTH-1:0] col);
    logic [7:0] chm;
    logic [3:0] km;
    chm = h ? ch : 8'd0;
    km  = e ? k : K_EOF;
    return {col, ln, km, e, chm, h};
  endfunction

  logic                 is_nl, is_tab, is_alpha, is_digit;
  logic [STEP_W-1:0]    col_step;
  logic [POS_WIDTH:0]   col_sum;
  logic [POS_WIDTH-1:0] adv_line, adv_col;
  logic [PH_W-1:0]      adv_ph;

  always_comb begin
    is_nl  = (c == CH_CR) || (c == CH_LF);
    is_tab = (c == CH_TAB);
    is_alpha = (c inside {[8'h41:8'h5A], [8'h61:8'h7A]});
    is_digit = (c inside {[8'h30:8'h39]});
    col_step = is_tab ? STEP_W'(STEP_W'(TAB_STOP) - STEP_W'(cur_ph)) : STEP_W'(1);
    col_sum  = {1'b0, cur_col} + (POS_WIDTH+1)'(col_step);
    if (is_nl) begin
      adv_line = (cur_line == POS_MAX) ? POS_MAX : cur_line + 1'b1;
      adv_col  = POS_WIDTH'(1);
      adv_ph   = '0;
    end else begin
      adv_line = cur_line;
      if (col_sum[POS_WIDTH]) begin
        adv_col = POS_MAX;
        adv_ph  = MAX_PH;
      end else begin
        adv_col = col_sum[POS_WIDTH-1:0];
        if (is_tab || (cur_ph == PH_W'(TAB_STOP - 1))) adv_ph = '0;
        else adv_ph = cur_ph + 1'b1;
      end
    end
  end

  logic                 adv, do_idle, do_str, do_nl;
  logic [CNT_W-1:0]     n;
  mode_t                m;
  logic                 ls;
  logic [7:0]           sc;
  logic [POS_WIDTH-1:0] tl, tc;

  always_comb begin
    adv = 1'b0; do_idle = 1'b0; do_str = 1'b0; do_nl = 1'b0;
    n = '0;
    for (int i = 0; i < REC_SLOTS; i++) recs[i] = '0;
    m  = ctl.mode;
    ls = ctl.line_started;
    sc = ctl.sign_char;
    tl = tok_row;
    tc = tok_col;

    if (op) begin
      case (ctl.mode)
        M_STRING: begin
          recs[n] = mk_rec(1'b0, 8'd0, 1'b1, K_UNKNOWN, tl, tc); n = n + 1'b1;
        end
        M_ESCAPE: begin
          recs[n] = mk_rec(1'b1, CH_BSLASH, 1'b1, K_UNKNOWN, tl, tc); n = n + 1'b1;
        end
        M_IDENT: begin
          recs[n] = mk_rec(1'b0, 8'd0, 1'b1, K_IDENT, tl, tc); n = n + 1'b1;
        end
        M_NUMBER: begin
          recs[n] = mk_rec(1'b0, 8'd0, 1'b1, K_NUMBER, tl, tc); n = n + 1'b1;
        end
        M_SIGN: begin
          recs[n] = mk_rec(1'b1, sc, 1'b1, K_UNKNOWN, tl, tc); n = n + 1'b1;
        end
        default: ;
      endcase
      recs[n] = mk_rec(1'b0, 8'd0, 1'b1, K_EOF, cur_line, cur_col); n = n + 1'b1;
      m = M_IDLE;
    end else if (!(ctl.cr_pending && c == CH_LF)) begin
      // LF straight after CR is part of the same newline
      case (ctl.mode)
        M_COMMENT: begin
          if (is_nl) do_nl = 1'b1;
          else adv = 1'b1;
        end
        M_STRING: do_str = 1'b1;
        M_ESCAPE: begin
          if (c == CH_QUOTE || c == CH_BSLASH) begin
            recs[n] = mk_rec(1'b1, c, 1'b0, K_EOF, tl, tc); n = n + 1'b1;
            m = M_STRING;
            adv = 1'b1;
          end else begin
            // lone backslash stays in the text
            recs[n] = mk_rec(1'b1, CH_BSLASH, 1'b0, K_EOF, tl, tc); n = n + 1'b1;
            do_str = 1'b1;
          end
        end
        M_IDENT: begin
          if (is_alpha || is_digit) begin
            recs[n] = mk_rec(1'b1, c, 1'b0, K_EOF, tl, tc); n = n + 1'b1;
            adv = 1'b1;
          end else if (c == CH_COLON) begin
            recs[n] = mk_rec(1'b0, 8'd0, 1'b1, K_LABEL, tl, tc); n = n + 1'b1;
            m = M_IDLE;
            adv = 1'b1;
          end else begin
            recs[n] = mk_rec(1'b0, 8'd0, 1'b1, K_IDENT, tl, tc); n = n + 1'b1;
            do_idle = 1'b1;
          end
        end
        M_NUMBER: begin
          if (is_digit) begin
            recs[n] = mk_rec(1'b1, c, 1'b0, K_EOF, tl, tc); n = n + 1'b1;
            adv = 1'b1;
          end else begin
            recs[n] = mk_rec(1'b0, 8'd0, 1'b1, K_NUMBER, tl, tc); n = n + 1'b1;
            do_idle = 1'b1;
          end
        end
        M_SIGN: begin
          if (is_digit) begin
            recs[n] = mk_rec(1'b1, sc, 1'b0, K_EOF, tl, tc); n = n + 1'b1;
            recs[n] = mk_rec(1'b1, c, 1'b0, K_EOF, tl, tc); n = n + 1'b1;
            m = M_NUMBER;
            adv = 1'b1;
          end else begin
            recs[n] = mk_rec(1'b1, sc, 1'b1, K_UNKNOWN, tl, tc); n = n + 1'b1;
            do_idle = 1'b1;
          end
        end
        default: do_idle = 1'b1;
      endcase

      if (do_str) begin
        m = M_STRING;
        if (c == CH_BSLASH) begin
          m = M_ESCAPE;
        end else if (c == CH_QUOTE) begin
          recs[n] = mk_rec(1'b0, 8'd0, 1'b1, K_STRING, tl, tc); n = n + 1'b1;
          m = M_IDLE;
        end else begin
          recs[n] = mk_rec(1'b1, c, 1'b0, K_EOF, tl, tc); n = n + 1'b1;
        end
        adv = 1'b1;
      end

      // byte seen between tokens; a token just ended falls through here too
      if (do_idle) begin
        m = M_IDLE;
        if (c == CH_SPACE || is_tab) begin
          adv = 1'b1;
        end else if (!ls && c == CH_LPAREN) begin
          m = M_COMMENT;
          adv = 1'b1;
        end else if (is_nl) begin
          do_nl = 1'b1;
        end else begin
          tl = cur_line;
          tc = cur_col;
          ls = 1'b1;
          if (c == CH_PCT) begin
            recs[n] = mk_rec(1'b1, c, 1'b1, K_PERCENT, tl, tc); n = n + 1'b1;
          end else if (c == CH_STAR) begin
            recs[n] = mk_rec(1'b1, c, 1'b1, K_STAR, tl, tc); n = n + 1'b1;
          end else if (c == CH_QUOTE) begin
            m = M_STRING;
          end else if (is_alpha) begin
            m = M_IDENT;
            recs[n] = mk_rec(1'b1, c, 1'b0, K_EOF, tl, tc); n = n + 1'b1;
          end else if (c == CH_PLUS || c == CH_MINUS) begin
            m = M_SIGN;
            sc = c;
          end else if (is_digit) begin
            m = M_NUMBER;
            recs[n] = mk_rec(1'b1, c, 1'b0, K_EOF, tl, tc); n = n + 1'b1;
          end else begin
            recs[n] = mk_rec(1'b1, c, 1'b1, K_UNKNOWN, tl, tc); n = n + 1'b1;
          end
          adv = 1'b1;
        end
      end

      if (do_nl) begin
        recs[n] = mk_rec(1'b1, CH_LF, 1'b1, K_NEWLINE, cur_line, cur_col); n = n + 1'b1;
        adv = 1'b1;
        ls  = 1'b0;
        m   = M_IDLE;
      end
    end

    rec_cnt = n;
    ctl_nxt.mode         = m;
    ctl_nxt.cr_pending   = !op && adv && (c == CH_CR);
    ctl_nxt.line_started = ls;
    ctl_nxt.sign_char    = sc;
    cur_line_nxt = adv ? adv_line : cur_line;
    cur_col_nxt  = adv ? adv_col  : cur_col;
    cur_ph_nxt   = adv ? adv_ph   : cur_ph;
    tok_row_nxt  = tl;
    tok_col_nxt  = tc;
  end

endmodule

// ----- hdl/alt_outq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alt_outq
// Result register: holds the records of one byte and hands them out in order.
// ----------------------------------------------------------------------------
module alt_outq import alt_pkg::*; #(
  parameter int REC_W = 46
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  logic [CNT_W-1:0] load_cnt,
  input  logic [REC_W-1:0] load_recs [REC_SLOTS],
  input  logic             out_tready,
  output logic             out_tvalid,
  output logic [REC_W-1:0] out_rec,
  output logic             out_last,
  output logic             can_load
);

  logic [REC_W-1:0] rec_r   [REC_SLOTS];
  logic [REC_W-1:0] rec_nxt [REC_SLOTS];
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             pop;

  assign out_tvalid = (cnt_r != '0);
  assign out_rec    = rec_r[0];
  assign out_last   = (cnt_r == CNT_W'(1));
  assign pop        = out_tvalid && out_tready;
  // free once the last held record leaves this cycle
  assign can_load   = (cnt_r == '0) || (out_last && out_tready);

  always_comb begin
    cnt_nxt = cnt_r - CNT_W'(pop);
    for (int i = 0; i < REC_SLOTS; i++) rec_nxt[i] = rec_r[i];
    if (pop) begin
      for (int i = 0; i < REC_SLOTS - 1; i++) rec_nxt[i] = rec_r[i+1];
    end
    if (load) begin
      cnt_nxt = load_cnt;
      for (int i = 0; i < REC_SLOTS; i++) rec_nxt[i] = load_recs[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < REC_SLOTS; i++) rec_r[i] <= rec_nxt[i];
  end

endmodule

// ----- hdl/assembly_line_tokenizer_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// assembly_line_tokenizer_core
// Line-based assembly source tokeniser, one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
// Input channel: in_tdata carries a source byte, in_tuser marks end of source
// (in_tdata is then ignored). Output channel: one record per transaction,
// carrying an optional text character and an optional token end with its kind
// and start position; out_tlast marks the final record caused by an input
// transaction. A byte that causes no record produces no output transaction.
// A byte accepted on the input lands in the input register and is scanned
// from there once the result register can take its records, which are then
// loaded into it. Throughput: one byte per cycle while each byte yields at
// most one record and out_tready stays high; further records of a byte hold
// the input while the single result port drains one record per ready cycle.
// Reset (synchronous, rst_n low) returns the scanner to line 1, column 1,
// between tokens, and drops any held records.
// When the receiver stalls the records stay put; one further byte is taken
// into the input register and then in_tready falls until the records drain.
// ----------------------------------------------------------------------------
module assembly_line_tokenizer_core import alt_pkg::*; #(
  parameter int POS_WIDTH = 16,
  parameter int TAB_STOP  = 8
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  logic [7:0] in_tdata,  // source_byte
  input  logic in_tuser,        // op
  output logic out_tvalid,
  input  logic out_tready,
  // has_char, text_char, ends_token, token_kind, start_line, start_column
  output logic [((REC_FIXED_W + 2*POS_WIDTH + 7) / 8) * 8 - 1:0] out_tdata,
  output logic out_tlast        // last_of_run
);

  localparam int REC_W  = REC_FIXED_W + 2 * POS_WIDTH;
  localparam int DATA_W = ((REC_W + 7) / 8) * 8;
  localparam int PH_W   = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;

  // input register
  logic       in_full_r;
  logic       op_r;
  logic [7:0] byte_r;

  scan_ctl_t            ctl_r, ctl_nxt;
  logic [POS_WIDTH-1:0] cur_line_r, cur_line_nxt, cur_col_r, cur_col_nxt;
  logic [POS_WIDTH-1:0] tok_row_r, tok_row_nxt, tok_col_r, tok_col_nxt;
  logic [PH_W-1:0]      cur_ph_r, cur_ph_nxt;

  logic [CNT_W-1:0] rec_cnt;
  logic [REC_W-1:0] recs [REC_SLOTS];
  logic [REC_W-1:0] out_rec;
  logic             can_load, step_fire;

  assign step_fire = in_full_r && can_load;
  assign in_tready = !in_full_r || step_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r <= 1'b0;
    end else if (in_tready) begin
      in_full_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      op_r   <= in_tuser;
      byte_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.mode         <= M_IDLE;
      ctl_r.cr_pending   <= 1'b0;
      ctl_r.line_started <= 1'b0;
      ctl_r.sign_char    <= 8'd0;
      cur_line_r <= POS_WIDTH'(1);
      cur_col_r  <= POS_WIDTH'(1);
      tok_row_r  <= POS_WIDTH'(1);
      tok_col_r  <= POS_WIDTH'(1);
      cur_ph_r   <= '0;
    end else if (step_fire) begin
      ctl_r      <= ctl_nxt;
      cur_line_r <= cur_line_nxt;
      cur_col_r  <= cur_col_nxt;
      tok_row_r  <= tok_row_nxt;
      tok_col_r  <= tok_col_nxt;
      cur_ph_r   <= cur_ph_nxt;
    end
  end

  alt_step #(
    .POS_WIDTH (POS_WIDTH),
    .TAB_STOP  (TAB_STOP),
    .PH_W      (PH_W),
    .REC_W     (REC_W)
  ) u_step (
    .op           (op_r),
    .c            (byte_r),
    .ctl          (ctl_r),
    .cur_line     (cur_line_r),
    .cur_col      (cur_col_r),
    .cur_ph       (cur_ph_r),
    .tok_row      (tok_row_r),
    .tok_col      (tok_col_r),
    .ctl_nxt      (ctl_nxt),
    .cur_line_nxt (cur_line_nxt),
    .cur_col_nxt  (cur_col_nxt),
    .cur_ph_nxt   (cur_ph_nxt),
    .tok_row_nxt  (tok_row_nxt),
    .tok_col_nxt  (tok_col_nxt),
    .rec_cnt      (rec_cnt),
    .recs         (recs)
  );

  alt_outq #(
    .REC_W (REC_W)
  ) u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (step_fire),
    .load_cnt   (rec_cnt),
    .load_recs  (recs),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_rec    (out_rec),
    .out_last   (out_tlast),
    .can_load   (can_load)
  );

  assign out_tdata = DATA_W'(out_rec);

`ifndef SYNTHESIS
  // a byte waiting in the input register is never dropped
  a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_full_r && !can_load |=> in_full_r)
    else $error("pending input transaction lost");

  // end of file is always the final record of its run
  a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_rec[9] && (out_rec[13:10] == K_EOF) |-> out_tlast)
    else $error("EOF record not marked last");

  // text character is zero when no character is carried
  a_char_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_rec[0] |-> (out_rec[8:1] == 8'd0))
    else $error("stray text character");
`endif

endmodule

// ----- tb/sv/tb_assembly_line_tokenizer_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_assembly_line_tokenizer_core
// Self-checking testbench for the streaming assembly line tokeniser.
// ----------------------------------------------------------------------------
// Source bytes and end-of-source markers are sent one transaction at a time.
// A scanner model inside the testbench works out the token records each byte
// should produce; every output transaction is checked field by field against
// the oldest outstanding record. Directed sequences cover comments, newline
// forms, labels, signed numbers, strings with escapes, stray bytes and end of
// source; a random stream of mostly well-formed tokens follows, then a burst
// with no idling on either side. Elsewhere both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_assembly_line_tokenizer_core;
  import alt_pkg::*;

  localparam int POS_W  = 16;
  localparam int TAB_W  = 8;
  localparam int OUT_W  = ((REC_FIXED_W + 2*POS_W + 7) / 8) * 8;
  localparam logic [POS_W-1:0] POS_MAX = '1;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_END  = 1'b1;

  localparam int IDLE_PCT       = 22;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_SHOWN      = 10;

  typedef struct {
    logic             has_char;
    logic [7:0]       text_char;
    logic             ends_token;
    kind_t            kind;
    logic [POS_W-1:0] line;
    logic [POS_W-1:0] column;
    logic             last;
  } tok_rec_t;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [7:0]       in_tdata   = 8'h00;
  logic             in_tuser   = 1'b0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic             out_tlast;

  logic no_idle = 1'b0;

  tok_rec_t expected_recs[$];
  tok_rec_t step_recs[$];
  int       fail_count  = 0;
  int       idle_cycles = 0;
  int       sent_items  = 0;

  // scanner model state
  mode_t            scan_mode;
  logic             cr_held;
  logic [POS_W-1:0] cur_line, cur_col, tok_row, tok_col;
  logic             line_open;
  logic [7:0]       held_sign;

  assembly_line_tokenizer_core #(
    .POS_WIDTH(POS_W),
    .TAB_STOP (TAB_W)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------- model

  function automatic logic [POS_W-1:0] sat_add(logic [POS_W-1:0] a, int unsigned b);
    int unsigned s;
    s = a + b;
    return (s > POS_MAX) ? POS_MAX : s[POS_W-1:0];
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic void reset_scan_state();
    scan_mode = M_IDLE;
    cr_held   = 1'b0;
    cur_line  = POS_W'(1);
    cur_col   = POS_W'(1);
    tok_row   = POS_W'(1);
    tok_col   = POS_W'(1);
    line_open = 1'b0;
    held_sign = 8'h00;
  endfunction

  function automatic void add_rec(logic h, logic [7:0] ch, logic e, kind_t k,
                                  logic [POS_W-1:0] ln, logic [POS_W-1:0] col);
    tok_rec_t r;
    r.has_char   = h;
    r.text_char  = h ? ch : 8'h00;
    r.ends_token = e;
    r.kind       = e ? k : K_EOF;
    r.line       = ln;
    r.column     = col;
    r.last       = 1'b0;
    step_recs = {step_recs, r};
  endfunction

  function automatic void add_tok(logic h, logic [7:0] ch, logic e, kind_t k);
    add_rec(h, ch, e, k, tok_row, tok_col);
  endfunction

  function automatic void move_pos(logic [7:0] c);
    int unsigned col0;
    if (c == CH_CR || c == CH_LF) begin
      cur_line = sat_add(cur_line, 1);
      cur_col  = POS_W'(1);
      if (c == CH_CR) cr_held = 1'b1;
    end else if (c == CH_TAB) begin
      col0    = cur_col - 1;
      cur_col = sat_add(cur_col, TAB_W - (col0 % TAB_W));
    end else begin
      cur_col = sat_add(cur_col, 1);
    end
  endfunction

  function automatic void newline_tok(logic [7:0] c);
    add_rec(1'b1, CH_LF, 1'b1, K_NEWLINE, cur_line, cur_col);
    move_pos(c);
    line_open = 1'b0;
    scan_mode = M_IDLE;
  endfunction

  function automatic void between_tokens(logic [7:0] c);
    scan_mode = M_IDLE;
    if (c == CH_SPACE || c == CH_TAB) begin
      move_pos(c);
    end else if (!line_open && c == CH_LPAREN) begin
      scan_mode = M_COMMENT;
      move_pos(c);
    end else if (c == CH_CR || c == CH_LF) begin
      newline_tok(c);
    end else begin
      tok_row   = cur_line;
      tok_col   = cur_col;
      line_open = 1'b1;
      if (c == CH_PCT) add_tok(1'b1, c, 1'b1, K_PERCENT);
      else if (c == CH_STAR) add_tok(1'b1, c, 1'b1, K_STAR);
      else if (c == CH_QUOTE) scan_mode = M_STRING;
      else if (is_alpha(c)) begin
        scan_mode = M_IDENT;
        add_tok(1'b1, c, 1'b0, K_EOF);
      end else if (c == CH_PLUS || c == CH_MINUS) begin
        scan_mode = M_SIGN;
        held_sign = c;
      end else if (is_digit(c)) begin
        scan_mode = M_NUMBER;
        add_tok(1'b1, c, 1'b0, K_EOF);
      end else add_tok(1'b1, c, 1'b1, K_UNKNOWN);
      move_pos(c);
    end
  endfunction

  function automatic void string_char(logic [7:0] c);
    scan_mode = M_STRING;
    if (c == CH_BSLASH) scan_mode = M_ESCAPE;
    else if (c == CH_QUOTE) begin
      add_tok(1'b0, 8'h00, 1'b1, K_STRING);
      scan_mode = M_IDLE;
    end else add_tok(1'b1, c, 1'b0, K_EOF);
    move_pos(c);
  endfunction

  function automatic void predict_records(logic op, logic [7:0] c);
    bit swallow;
    step_recs.delete();
    if (op == OP_END) begin
      case (scan_mode)
        M_STRING: add_tok(1'b0, 8'h00, 1'b1, K_UNKNOWN);
        M_ESCAPE: add_tok(1'b1, CH_BSLASH, 1'b1, K_UNKNOWN);
        M_IDENT:  add_tok(1'b0, 8'h00, 1'b1, K_IDENT);
        M_NUMBER: add_tok(1'b0, 8'h00, 1'b1, K_NUMBER);
        M_SIGN:   add_tok(1'b1, held_sign, 1'b1, K_UNKNOWN);
        default:  ;
      endcase
      add_rec(1'b0, 8'h00, 1'b1, K_EOF, cur_line, cur_col);
      scan_mode = M_IDLE;
      cr_held   = 1'b0;
    end else begin
      // LF straight after CR belongs to the same newline
      swallow = cr_held && c == CH_LF;
      cr_held = 1'b0;
      if (!swallow) begin
        case (scan_mode)
          M_COMMENT: begin
            if (c == CH_CR || c == CH_LF) newline_tok(c);
            else move_pos(c);
          end
          M_STRING: string_char(c);
          M_ESCAPE: begin
            if (c == CH_QUOTE || c == CH_BSLASH) begin
              add_tok(1'b1, c, 1'b0, K_EOF);
              scan_mode = M_STRING;
              move_pos(c);
            end else begin
              add_tok(1'b1, CH_BSLASH, 1'b0, K_EOF);
              string_char(c);
            end
          end
          M_IDENT: begin
            if (is_alpha(c) || is_digit(c)) begin
              add_tok(1'b1, c, 1'b0, K_EOF);
              move_pos(c);
            end else if (c == CH_COLON) begin
              add_tok(1'b0, 8'h00, 1'b1, K_LABEL);
              scan_mode = M_IDLE;
              move_pos(c);
            end else begin
              add_tok(1'b0, 8'h00, 1'b1, K_IDENT);
              between_tokens(c);
            end
          end
          M_NUMBER: begin
            if (is_digit(c)) begin
              add_tok(1'b1, c, 1'b0, K_EOF);
              move_pos(c);
            end else begin
              add_tok(1'b0, 8'h00, 1'b1, K_NUMBER);
              between_tokens(c);
            end
          end
          M_SIGN: begin
            if (is_digit(c)) begin
              add_tok(1'b1, held_sign, 1'b0, K_EOF);
              add_tok(1'b1, c, 1'b0, K_EOF);
              scan_mode = M_NUMBER;
              move_pos(c);
            end else begin
              add_tok(1'b1, held_sign, 1'b1, K_UNKNOWN);
              between_tokens(c);
            end
          end
          default: between_tokens(c);
        endcase
      end
    end
    if (step_recs.size() > 0) begin
      step_recs[step_recs.size() - 1].last = 1'b1;
      foreach (step_recs[i]) expected_recs = {expected_recs, step_recs[i]};
    end
  endfunction

  // ------------------------------------------------------------ stimulus

  task automatic send_item(logic op, logic [7:0] c);
    if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < IDLE_PCT) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= c;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_records(op, c);
    sent_items++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_item(OP_BYTE, s[i]);
  endtask

  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    while (expected_recs.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_letter();
    return $urandom_range(1) ? 8'($urandom_range(65, 90)) : 8'($urandom_range(97, 122));
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'($urandom_range(48, 57));
  endfunction

  task automatic send_fragment();
    int pick;
    pick = $urandom_range(15);
    case (pick)
      0, 1, 2: begin
        send_item(OP_BYTE, rand_letter());
        repeat ($urandom_range(4))
          send_item(OP_BYTE, $urandom_range(1) ? rand_letter() : rand_digit());
        if (pick == 0) send_item(OP_BYTE, CH_COLON);
      end
      3, 4: begin
        if (pick == 4) send_item(OP_BYTE, $urandom_range(1) ? CH_PLUS : CH_MINUS);
        repeat ($urandom_range(1, 4)) send_item(OP_BYTE, rand_digit());
      end
      5, 6: begin
        send_item(OP_BYTE, CH_QUOTE);
        repeat ($urandom_range(5)) begin
          case ($urandom_range(5))
            0: begin
              send_item(OP_BYTE, CH_BSLASH);
              send_item(OP_BYTE, CH_QUOTE);
            end
            1: begin
              send_item(OP_BYTE, CH_BSLASH);
              send_item(OP_BYTE, CH_BSLASH);
            end
            2: begin
              send_item(OP_BYTE, CH_BSLASH);
              send_item(OP_BYTE, rand_letter());
            end
            3: send_item(OP_BYTE, $urandom_range(1) ? CH_SPACE : CH_TAB);
            default: send_item(OP_BYTE, rand_letter());
          endcase
        end
        // mostly closed, now and then left open
        if ($urandom_range(9) != 0) send_item(OP_BYTE, CH_QUOTE);
      end
      7: send_item(OP_BYTE, CH_PCT);
      8: send_item(OP_BYTE, CH_STAR);
      9, 10: send_item(OP_BYTE, $urandom_range(1) ? CH_SPACE : CH_TAB);
      11: begin
        case ($urandom_range(2))
          0: send_item(OP_BYTE, CH_LF);
          1: send_item(OP_BYTE, CH_CR);
          default: begin
            send_item(OP_BYTE, CH_CR);
            send_item(OP_BYTE, CH_LF);
          end
        endcase
      end
      12: begin
        send_item(OP_BYTE, CH_LPAREN);
        repeat ($urandom_range(4)) send_item(OP_BYTE, 8'($urandom_range(32, 126)));
      end
      13: send_item(OP_BYTE, 8'($urandom_range(255)));
      14: begin
        if ($urandom_range(3) == 0) send_item(OP_END, 8'($urandom_range(255)));
        else send_item(OP_BYTE, 8'($urandom_range(255)));
      end
      default: begin
        send_item(OP_BYTE, $urandom_range(1) ? CH_PLUS : CH_MINUS);
        case ($urandom_range(3))
          0: send_item(OP_BYTE, CH_SPACE);
          1: send_item(OP_BYTE, rand_letter());
          2: send_item(OP_BYTE, CH_PCT);
          default: send_item(OP_BYTE, CH_CR);
        endcase
      end
    endcase
  endtask

  // ---------------------------------------------------------------- tests

  // comment at the start of a line, CR LF as one newline, bare LF
  task automatic test_comments_and_newlines();
    send_text("(c");
    send_item(OP_BYTE, CH_CR);
    send_item(OP_BYTE, CH_LF);
    send_item(OP_BYTE, CH_LF);
  endtask

  // label, tab, signed number ended by '(' (not a comment mid-line), bare sign
  task automatic test_labels_and_signs();
    send_text("x1:");
    send_item(OP_BYTE, CH_TAB);
    send_text("-9(+*");
    send_item(OP_BYTE, CH_CR);
  endtask

  // escapes, backslash before an ordinary char, CR LF inside a string
  task automatic test_strings_and_escapes();
    send_item(OP_BYTE, CH_QUOTE);
    send_item(OP_BYTE, CH_BSLASH);
    send_text("q");
    send_item(OP_BYTE, CH_BSLASH);
    send_item(OP_BYTE, CH_QUOTE);
    send_item(OP_BYTE, CH_CR);
    send_item(OP_BYTE, CH_LF);
    send_item(OP_BYTE, CH_QUOTE);
    // string left open on a held backslash
    send_item(OP_BYTE, CH_QUOTE);
    send_item(OP_BYTE, CH_BSLASH);
    send_item(OP_END, 8'h00);
  endtask

  // stray bytes at both extremes, pending tokens closed by end of source
  task automatic test_end_of_source();
    send_item(OP_BYTE, 8'h00);
    send_item(OP_BYTE, 8'hFF);
    send_text("ab");
    send_item(OP_END, 8'hFF);
    send_item(OP_END, 8'h00);
    send_text("-");
    send_item(OP_END, 8'h5A);
  endtask

  task automatic test_random_stream(int n_items);
    int stop_at;
    stop_at = sent_items + n_items;
    while (sent_items < stop_at) begin
      send_fragment();
      if ($urandom_range(2) == 0) send_item(OP_BYTE, CH_SPACE);
    end
  endtask

  // runs without any idling on either side
  task automatic test_no_idle_burst();
    no_idle = 1'b1;
    test_random_stream(30);
    wait_for_results();
    no_idle = 1'b0;
  endtask

  // ------------------------------------------------------------- checking

  always @(posedge clk) begin
    out_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin : check_records
    tok_rec_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_recs.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_SHOWN)
          $display("unexpected token record: tdata=%h last=%0d", out_tdata, out_tlast);
      end else begin
        want = expected_recs.pop_front();
        if (out_tdata[0] !== want.has_char || out_tdata[8:1] !== want.text_char ||
            out_tdata[9] !== want.ends_token || out_tdata[13:10] !== want.kind ||
            out_tdata[29:14] !== want.line || out_tdata[45:30] !== want.column ||
            out_tlast !== want.last) begin
          fail_count++;
          if (fail_count <= MAX_SHOWN) begin
            $display("record mismatch: expected char=%0d/%h end=%0d kind=%0d pos=%0d:%0d last=%0d",
                     want.has_char, want.text_char, want.ends_token, want.kind,
                     want.line, want.column, want.last);
            $display("                 actual   char=%0d/%h end=%0d kind=%0d pos=%0d:%0d last=%0d",
                     out_tdata[0], out_tdata[8:1], out_tdata[9], out_tdata[13:10],
                     out_tdata[29:14], out_tdata[45:30], out_tlast);
          end
        end
      end
    end
  end

  // ends the run if neither channel moves a transaction for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    reset_scan_state();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_comments_and_newlines();
    test_labels_and_signs();
    test_strings_and_escapes();
    test_end_of_source();
    test_random_stream(165);
    wait_for_results();
    test_no_idle_burst();
    if (fail_count == 0 && expected_recs.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/alt_pkg.sv
hdl/alt_step.sv
hdl/alt_outq.sv
hdl/assembly_line_tokenizer_core.sv
tb/sv/tb_assembly_line_tokenizer_core.sv
